[src/imu_sct_pkg.sv]
// Shared constants, tables, saturation helpers and state types for the IMU scaler.
`timescale 1ns / 1ps
package imu_sct_pkg;

   localparam int MAX_CAL_SAMPLES_DEF = 256;
   localparam int CORDIC_STEPS_DEF    = 16;

   localparam int RAW_W   = 16;
   localparam int ACC_W   = 19;
   localparam int GYR_W   = 18;
   localparam int TEMP_W  = 17;
   localparam int ANG_W   = 14;
   localparam int LANE_W  = ACC_W + 1;
   localparam int CRD_W   = 36;
   localparam int PHASE_W = 25;
   localparam int STEP_W  = 5;
   localparam int SAT_W   = 48;
   localparam int RECIP_W = 24;
   localparam int GPROD_W = RAW_W + RECIP_W + 1;
   localparam int TNUM_W  = 32;
   localparam int TMAG_W  = 31;
   localparam int TRED_W  = 27;
   localparam int TRCP_W  = 28;
   localparam int TPROD_W = TRED_W + TRCP_W;

   // numerator and 34000 share a factor of 16; what is left is a divide by 2125
   localparam logic [TRED_W-1:0] TEMP_BIAS  = 27'd1062;
   localparam logic [TRCP_W-1:0] TEMP_RECIP = 28'd258708619;
   localparam int TEMP_SHIFT = 39;
   localparam logic signed [TNUM_W-1:0] TEMP_OFS = 32'sd317957120;
   localparam logic signed [TNUM_W-1:0] TEMP_MUL = 32'sd25600;
   localparam logic signed [16:0] CORDIC_GAIN  = 17'sd39797;
   localparam int ANG_LIMIT = 5760;
   localparam int ONE_G     = 16384;

   localparam logic [1:0] CSR_GYRO_RANGE  = 2'd0;
   localparam logic [1:0] CSR_ACCEL_RANGE = 2'd1;
   localparam logic [1:0] CSR_CAL_SAMPLES = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCALE, ST_CORR, ST_LAUNCH, ST_RUN, ST_OUT
   } ctl_state_type;

   typedef enum logic [1:0] {
      LS_IDLE, LS_PASS1, LS_GAIN, LS_PASS2
   } lane_state_type;

   // arctangent of 2^-i in degrees, Q16
   function automatic logic [22:0] atan_entry(input logic [STEP_W-1:0] idx);
      logic [22:0] v;
      case (idx)
         5'd0:  v = 23'd2949120;
         5'd1:  v = 23'd1740967;
         5'd2:  v = 23'd919879;
         5'd3:  v = 23'd466945;
         5'd4:  v = 23'd234379;
         5'd5:  v = 23'd117305;
         5'd6:  v = 23'd58666;
         5'd7:  v = 23'd29335;
         5'd8:  v = 23'd14668;
         5'd9:  v = 23'd7334;
         5'd10: v = 23'd3667;
         5'd11: v = 23'd1833;
         5'd12: v = 23'd917;
         5'd13: v = 23'd458;
         5'd14: v = 23'd229;
         5'd15: v = 23'd115;
         5'd16: v = 23'd57;
         5'd17: v = 23'd29;
         5'd18: v = 23'd14;
         5'd19: v = 23'd7;
         5'd20: v = 23'd4;
         5'd21: v = 23'd2;
         5'd22: v = 23'd1;
         default: v = 23'd0;
      endcase
      return v;
   endfunction

   // Q22 reciprocal of the gyro sensitivity, scaled to 1/64 deg/s
   function automatic logic [RECIP_W-1:0] gyro_recip(input logic [1:0] rng);
      logic [RECIP_W-1:0] v;
      case (rng)
         2'd0:    v = 24'd2049126;
         2'd1:    v = 24'd4098251;
         2'd2:    v = 24'd8184008;
         default: v = 24'd16368016;
      endcase
      return v;
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'((64'sd1 <<< (ACC_W - 1)) - 64'sd1);
      lo = -hi - SAT_W'(1);
      if (v > hi) return ACC_W'(hi);
      else if (v < lo) return ACC_W'(lo);
      else return ACC_W'(v);
   endfunction

   function automatic logic signed [GYR_W-1:0] sat_gyr(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = SAT_W'((64'sd1 <<< (GYR_W - 1)) - 64'sd1);
      lo = -hi - SAT_W'(1);
      if (v > hi) return GYR_W'(hi);
      else if (v < lo) return GYR_W'(lo);
      else return GYR_W'(v);
   endfunction

endpackage

[src/imu_sample_scale_calibrate_tilt.sv]
// Top level: sample scaling, offset calibration and tilt merge for the IMU.
//
//   channel | direction | handshake          | beat
//   req_    | in        | req_valid/req_stall | action and seven raw words
//   rsp_    | out       | rsp_valid/rsp_stall | corrected sample, tilt, flags
//   csr_    | in        | csr_valid/csr_ready | register index and data
//
// A new beat is taken only once the last result is in the output register; the wait
// is set by the CORDIC lanes, the average dividers on a run's last beat, and rsp_stall.
// The average dividers run only on the beat that ends a calibration run.
// Reset is synchronous; it clears ranges, offsets and the run count.
// The output register holds a result under rsp_stall while the next beat is taken.
`timescale 1ns / 1ps
module imu_sample_scale_calibrate_tilt
   import imu_sct_pkg::*;
#(
   parameter int MAX_CAL_SAMPLES = MAX_CAL_SAMPLES_DEF,
   parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic signed [RAW_W-1:0]   req_raw_ax,
   input  logic signed [RAW_W-1:0]   req_raw_ay,
   input  logic signed [RAW_W-1:0]   req_raw_az,
   input  logic signed [RAW_W-1:0]   req_raw_temp,
   input  logic signed [RAW_W-1:0]   req_raw_gx,
   input  logic signed [RAW_W-1:0]   req_raw_gy,
   input  logic signed [RAW_W-1:0]   req_raw_gz,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [ACC_W-1:0]   rsp_accel_x,
   output logic signed [ACC_W-1:0]   rsp_accel_y,
   output logic signed [ACC_W-1:0]   rsp_accel_z,
   output logic signed [GYR_W-1:0]   rsp_gyro_x,
   output logic signed [GYR_W-1:0]   rsp_gyro_y,
   output logic signed [GYR_W-1:0]   rsp_gyro_z,
   output logic signed [TEMP_W-1:0]  rsp_temperature,
   output logic signed [ANG_W-1:0]   rsp_pitch,
   output logic signed [ANG_W-1:0]   rsp_roll,
   output logic                      rsp_calibrating,
   output logic                      rsp_cal_done,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [8:0]                csr_wdata
);

   localparam int CNT_W  = $clog2(MAX_CAL_SAMPLES + 1);
   localparam int ASUM_W = ACC_W + $clog2(MAX_CAL_SAMPLES);
   localparam int GSUM_W = GYR_W + $clog2(MAX_CAL_SAMPLES);

   ctl_state_type state_ff, state_in;
   logic accept, start_units, load_out, units_idle;

   // configuration
   logic [1:0] gyro_range_ff, accel_range_ff;
   logic [8:0] cal_samples_ff;

   // captured beat
   logic                    action_ff;
   logic signed [RAW_W-1:0] raw_acc_ff [3];
   logic signed [RAW_W-1:0] raw_gyr_ff [3];
   logic signed [RAW_W-1:0] raw_temp_ff;

   // scaled values
   logic signed [ACC_W-1:0]   sa_ff    [3];
   logic signed [GPROD_W-1:0] gprod_ff [3];
   logic signed [TNUM_W-1:0]  tprod_ff;

   // corrected values
   logic signed [ACC_W-1:0]  ca_ff [3];
   logic signed [GYR_W-1:0]  cg_ff [3];
   logic signed [TNUM_W-1:0] tnum_ff;

   // calibration state
   logic signed [ACC_W-1:0]  aoff_ff [3];
   logic signed [GYR_W-1:0]  goff_ff [3];
   logic signed [ASUM_W-1:0] asum_ff [3];
   logic signed [GSUM_W-1:0] gsum_ff [3];
   logic [CNT_W-1:0]         count_ff;
   logic signed [ASUM_W-1:0] asumd_ff [3];
   logic signed [GSUM_W-1:0] gsumd_ff [3];
   logic [CNT_W-1:0]         dcnt_ff;
   logic                     done_ff;

   // output register
   logic                     rsp_valid_ff;
   logic signed [ACC_W-1:0]  out_acc_ff [3];
   logic signed [GYR_W-1:0]  out_gyr_ff [3];
   logic signed [TEMP_W-1:0] out_temp_ff;
   logic signed [ANG_W-1:0]  out_pitch_ff, out_roll_ff;
   logic                     out_cal_ff, out_done_ff;

   // combinational correction
   logic                     off_clear;
   logic signed [ACC_W-1:0]  ca_in  [3];
   logic signed [GYR_W-1:0]  cg_in  [3];
   logic signed [GYR_W-1:0]  sg     [3];
   logic [GPROD_W-1:0]       gmag   [3];
   logic [GPROD_W-1:0]       gq     [3];
   logic signed [ASUM_W-1:0] asum_in [3];
   logic signed [GSUM_W-1:0] gsum_in [3];
   logic [CNT_W-1:0]         count_next;
   logic [31:0]              lim;
   logic                     cal_fin;

   // unit interfaces
   logic [TMAG_W-1:0]  tmag;
   logic [TRED_W-1:0]  tred;
   logic [TPROD_W-1:0] tmul;
   logic [TEMP_W-1:0]  tquot_ff;
   logic [ASUM_W-1:0]  adiv_num [3];
   logic [ASUM_W-1:0]  adiv_quot [3];
   logic [GSUM_W-1:0]  gdiv_num [3];
   logic [GSUM_W-1:0]  gdiv_quot [3];
   logic [5:0]         cdiv_busy;
   logic               pitch_busy, roll_busy;
   logic signed [ANG_W-1:0] pitch_ang, roll_ang;
   logic signed [TEMP_W-1:0] temp_val;
   logic signed [ACC_W-1:0]  aoff_new [3];
   logic signed [GYR_W-1:0]  goff_new [3];

   // ---------------- control ----------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_SCALE;
         ST_SCALE:  state_in = ST_CORR;
         ST_CORR:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_RUN;
         ST_RUN:    if (units_idle) state_in = ST_OUT;
         ST_OUT:    if (load_out) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = 1'b1;
      start_units = 1'b0;
      load_out    = 1'b0;
      unique case (state_ff)
         ST_IDLE:   req_stall = 1'b0;
         ST_LAUNCH: start_units = 1'b1;
         ST_OUT:    load_out = !rsp_valid_ff || !rsp_stall;
         default:   req_stall = 1'b1;
      endcase
   end

   assign accept     = req_valid && !req_stall;
   assign units_idle = !pitch_busy && !roll_busy && (cdiv_busy == '0);

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------- configuration ----------------
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_range_ff  <= '0;
         accel_range_ff <= '0;
         cal_samples_ff <= 9'd100;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_GYRO_RANGE:  gyro_range_ff  <= csr_wdata[1:0];
            CSR_ACCEL_RANGE: accel_range_ff <= csr_wdata[1:0];
            CSR_CAL_SAMPLES: cal_samples_ff <= csr_wdata;
            default:         ;
         endcase
      end
   end

   // ---------------- capture and scale ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff     <= req_action;
         raw_acc_ff[0] <= req_raw_ax;
         raw_acc_ff[1] <= req_raw_ay;
         raw_acc_ff[2] <= req_raw_az;
         raw_gyr_ff[0] <= req_raw_gx;
         raw_gyr_ff[1] <= req_raw_gy;
         raw_gyr_ff[2] <= req_raw_gz;
         raw_temp_ff   <= req_raw_temp;
      end
      if (state_ff == ST_SCALE) begin
         for (int k = 0; k < 3; k++) begin
            sa_ff[k]    <= ACC_W'(raw_acc_ff[k]) <<< accel_range_ff;
            gprod_ff[k] <= GPROD_W'(raw_gyr_ff[k])
                           * $signed({1'b0, gyro_recip(gyro_range_ff)});
         end
         tprod_ff <= TNUM_W'(raw_temp_ff) * TEMP_MUL;
      end
   end

   // ---------------- offset correction and accumulation ----------------
   always_comb begin
      off_clear  = action_ff && (count_ff == '0);
      count_next = count_ff + CNT_W'(1);
      if (cal_samples_ff == '0)
         lim = 32'd1;
      else if (32'(cal_samples_ff) > 32'(MAX_CAL_SAMPLES))
         lim = 32'(MAX_CAL_SAMPLES);
      else
         lim = 32'(cal_samples_ff);
      cal_fin = action_ff && (32'(count_next) >= lim);
      for (int k = 0; k < 3; k++) begin
         gmag[k] = gprod_ff[k] < 0 ? GPROD_W'(-gprod_ff[k]) : GPROD_W'(gprod_ff[k]);
         gq[k]   = (gmag[k] + GPROD_W'(64'd2097152)) >> 22;
         sg[k]   = gprod_ff[k] < 0 ? -GYR_W'(gq[k]) : GYR_W'(gq[k]);
         ca_in[k] = sat_acc(SAT_W'(sa_ff[k]) - (off_clear ? '0 : SAT_W'(aoff_ff[k])));
         cg_in[k] = sat_gyr(SAT_W'(sg[k]) - (off_clear ? '0 : SAT_W'(goff_ff[k])));
         asum_in[k] = (count_ff == '0 ? '0 : asum_ff[k]) + ASUM_W'(sa_ff[k]);
         gsum_in[k] = (count_ff == '0 ? '0 : gsum_ff[k]) + GSUM_W'(sg[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CORR) begin
         for (int k = 0; k < 3; k++) begin
            ca_ff[k]    <= ca_in[k];
            cg_ff[k]    <= cg_in[k];
            asum_ff[k]  <= asum_in[k];
            gsum_ff[k]  <= gsum_in[k];
            asumd_ff[k] <= asum_in[k];
            gsumd_ff[k] <= gsum_in[k];
         end
         tnum_ff <= tprod_ff + TEMP_OFS;
         dcnt_ff <= count_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            aoff_ff[k] <= '0;
            goff_ff[k] <= '0;
         end
      end else if (state_ff == ST_CORR) begin
         done_ff <= cal_fin;
         if (action_ff) begin
            count_ff <= cal_fin ? '0 : count_next;
            if (off_clear) begin
               for (int k = 0; k < 3; k++) begin
                  aoff_ff[k] <= '0;
                  goff_ff[k] <= '0;
               end
            end
         end else begin
            // a normal beat drops a running calibration
            count_ff <= '0;
         end
      end else if (load_out && done_ff) begin
         for (int k = 0; k < 3; k++) begin
            aoff_ff[k] <= aoff_new[k];
            goff_ff[k] <= goff_new[k];
         end
      end
   end

   // ---------------- arithmetic lanes ----------------
   // divide by 2125 as a reciprocal multiply, exact over the 27-bit reduced range
   assign tmag = tnum_ff < 0 ? TMAG_W'(-tnum_ff) : TMAG_W'(tnum_ff);
   assign tred = TRED_W'(tmag >> 4) + TEMP_BIAS;
   assign tmul = TPROD_W'(tred) * TPROD_W'(TEMP_RECIP);

   always_ff @(posedge clock) begin
      if (start_units) tquot_ff <= TEMP_W'(tmul >> TEMP_SHIFT);
   end

   assign temp_val = tnum_ff < 0 ? -tquot_ff : tquot_ff;

   for (genvar k = 0; k < 3; k++) begin : g_cal
      assign adiv_num[k] = (asumd_ff[k] < 0 ? ASUM_W'(-asumd_ff[k]) : ASUM_W'(asumd_ff[k]))
                           + ASUM_W'(dcnt_ff >> 1);
      assign gdiv_num[k] = (gsumd_ff[k] < 0 ? GSUM_W'(-gsumd_ff[k]) : GSUM_W'(gsumd_ff[k]))
                           + GSUM_W'(dcnt_ff >> 1);

      imu_sct_div #(.NUM_W(ASUM_W), .DEN_W(CNT_W)) u_acc_div (
         .clock (clock),
         .reset (reset),
         .start (start_units && done_ff),
         .num   (adiv_num[k]),
         .den   (dcnt_ff),
         .busy  (cdiv_busy[k]),
         .quot  (adiv_quot[k])
      );

      imu_sct_div #(.NUM_W(GSUM_W), .DEN_W(CNT_W)) u_gyr_div (
         .clock (clock),
         .reset (reset),
         .start (start_units && done_ff),
         .num   (gdiv_num[k]),
         .den   (dcnt_ff),
         .busy  (cdiv_busy[3 + k]),
         .quot  (gdiv_quot[k])
      );

      always_comb begin
         logic signed [SAT_W-1:0] av;
         logic signed [SAT_W-1:0] gv;
         av = asumd_ff[k] < 0 ? -SAT_W'(adiv_quot[k]) : SAT_W'(adiv_quot[k]);
         if (k == 2) av = av - SAT_W'(ONE_G);
         gv = gsumd_ff[k] < 0 ? -SAT_W'(gdiv_quot[k]) : SAT_W'(gdiv_quot[k]);
         aoff_new[k] = sat_acc(av);
         goff_new[k] = sat_gyr(gv);
      end
   end

   imu_sct_tilt_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_pitch (
      .clock  (clock),
      .reset  (reset),
      .start  (start_units),
      .num    (LANE_W'(ca_ff[1])),
      .axis_a (LANE_W'(ca_ff[0])),
      .axis_b (LANE_W'(ca_ff[2])),
      .busy   (pitch_busy),
      .angle  (pitch_ang)
   );

   imu_sct_tilt_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_roll (
      .clock  (clock),
      .reset  (reset),
      .start  (start_units),
      .num    (-LANE_W'(ca_ff[0])),
      .axis_a (LANE_W'(ca_ff[1])),
      .axis_b (LANE_W'(ca_ff[2])),
      .busy   (roll_busy),
      .angle  (roll_ang)
   );

   // ---------------- merge into output register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         for (int k = 0; k < 3; k++) begin
            out_acc_ff[k] <= ca_ff[k];
            out_gyr_ff[k] <= cg_ff[k];
         end
         out_temp_ff  <= temp_val;
         out_pitch_ff <= pitch_ang;
         out_roll_ff  <= roll_ang;
         out_cal_ff   <= count_ff != '0;
         out_done_ff  <= done_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_accel_x     = out_acc_ff[0];
   assign rsp_accel_y     = out_acc_ff[1];
   assign rsp_accel_z     = out_acc_ff[2];
   assign rsp_gyro_x      = out_gyr_ff[0];
   assign rsp_gyro_y      = out_gyr_ff[1];
   assign rsp_gyro_z      = out_gyr_ff[2];
   assign rsp_temperature = out_temp_ff;
   assign rsp_pitch       = out_pitch_ff;
   assign rsp_roll        = out_roll_ff;
   assign rsp_calibrating = out_cal_ff;
   assign rsp_cal_done    = out_done_ff;

endmodule

[src/imu_sct_div.sv]
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module imu_sct_div
   import imu_sct_pkg::*;
#(
   parameter int NUM_W = 32,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             busy,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[NUM_W-1]};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
      quo_in = {quo_ff[NUM_W-2:0], fits};
      cnt_in = cnt_ff - CNT_W'(1);
      busy_in = cnt_ff != CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff) begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= num;
         rem_ff <= '0;
         den_ff <= den;
         cnt_ff <= CNT_W'(NUM_W);
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign quot = quo_ff;

endmodule

[src/imu_sct_tilt_lane.sv]
// CORDIC tilt lane: magnitude of two axes, then atan2 against the third.
`timescale 1ns / 1ps
module imu_sct_tilt_lane
   import imu_sct_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [LANE_W-1:0] num,
   input  logic signed [LANE_W-1:0] axis_a,
   input  logic signed [LANE_W-1:0] axis_b,
   output logic                     busy,
   output logic signed [ANG_W-1:0]  angle
);

   lane_state_type state_ff, state_in;

   logic signed [CRD_W-1:0]   x_ff, y_ff;
   logic signed [PHASE_W-1:0] ang_ff;
   logic [STEP_W-1:0]         step_ff;
   logic signed [LANE_W-1:0]  num_ff;
   logic                      zero_ff;
   logic                      iterate, last;

   logic signed [LANE_W-1:0]     abs_a, abs_b;
   logic signed [CRD_W-1:0]      xs, ys;
   logic signed [PHASE_W-1:0]    tab;
   logic signed [CRD_W+16:0]     gprod;
   logic signed [CRD_W-1:0]      mag;
   logic [PHASE_W-1:0]           amag;
   logic [PHASE_W-1:0]           rnd;
   logic [PHASE_W-1:0]           clip;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         LS_IDLE:  if (start) state_in = LS_PASS1;
         LS_PASS1: if (last) state_in = LS_GAIN;
         LS_GAIN:  state_in = LS_PASS2;
         LS_PASS2: if (last) state_in = LS_IDLE;
         default:  state_in = LS_IDLE;
      endcase
   end

   // state decode
   always_comb begin
      busy    = 1'b0;
      iterate = 1'b0;
      unique case (state_ff)
         LS_IDLE:  busy = 1'b0;
         LS_PASS1: begin busy = 1'b1; iterate = 1'b1; end
         LS_GAIN:  busy = 1'b1;
         LS_PASS2: begin busy = 1'b1; iterate = 1'b1; end
         default:  busy = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= LS_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      last  = step_ff == STEP_W'(CORDIC_STEPS - 1);
      abs_a = axis_a < 0 ? -axis_a : axis_a;
      abs_b = axis_b < 0 ? -axis_b : axis_b;
      xs    = x_ff >>> step_ff;
      ys    = y_ff >>> step_ff;
      tab   = $signed({2'b00, atan_entry(step_ff)});
      gprod = x_ff * CORDIC_GAIN;
      mag   = CRD_W'(gprod >>> 16);
   end

   always_ff @(posedge clock) begin
      if (state_ff == LS_IDLE && start) begin
         x_ff    <= CRD_W'(abs_a) <<< 12;
         y_ff    <= CRD_W'(abs_b) <<< 12;
         ang_ff  <= '0;
         step_ff <= '0;
         num_ff  <= num;
      end else if (iterate) begin
         if (y_ff >= 0) begin
            x_ff   <= x_ff + ys;
            y_ff   <= y_ff - xs;
            ang_ff <= ang_ff + tab;
         end else begin
            x_ff   <= x_ff - ys;
            y_ff   <= y_ff + xs;
            ang_ff <= ang_ff - tab;
         end
         step_ff <= last ? '0 : step_ff + STEP_W'(1);
      end else if (state_ff == LS_GAIN) begin
         x_ff    <= mag;
         y_ff    <= CRD_W'(num_ff) <<< 12;
         ang_ff  <= '0;
         zero_ff <= (mag == 0) && (num_ff == 0);
      end
   end

   // round to 1/64 degree and clamp
   always_comb begin
      amag = ang_ff < 0 ? PHASE_W'(-ang_ff) : PHASE_W'(ang_ff);
      rnd  = (amag + PHASE_W'(512)) >> 10;
      clip = rnd > PHASE_W'(ANG_LIMIT) ? PHASE_W'(ANG_LIMIT) : rnd;
      if (zero_ff)        angle = '0;
      else if (ang_ff < 0) angle = -ANG_W'(clip);
      else                angle = ANG_W'(clip);
   end

endmodule

[tb/tb_imu_sample_scale_calibrate_tilt.sv]
// Self-checking testbench for the IMU sample scaler, calibration and tilt block.
`timescale 1ns / 1ps
module tb_imu_sample_scale_calibrate_tilt;
   import imu_sct_pkg::*;

   localparam int LIMIT_CYCLES = 900000;
   localparam int MAX_CAL = 256;
   localparam int STEPS = 16;
   localparam int SETTLE = 60;

   typedef struct {
      logic signed [ACC_W-1:0]  ax, ay, az;
      logic signed [GYR_W-1:0]  gx, gy, gz;
      logic signed [TEMP_W-1:0] temp;
      logic signed [ANG_W-1:0]  pitch, roll;
      logic                     calibrating, done;
   } sample_out_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_action = 1'b0;
   logic signed [RAW_W-1:0] req_raw_ax = '0, req_raw_ay = '0, req_raw_az = '0;
   logic signed [RAW_W-1:0] req_raw_temp = '0, req_raw_gx = '0, req_raw_gy = '0;
   logic signed [RAW_W-1:0] req_raw_gz = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [ACC_W-1:0] rsp_accel_x, rsp_accel_y, rsp_accel_z;
   logic signed [GYR_W-1:0] rsp_gyro_x, rsp_gyro_y, rsp_gyro_z;
   logic signed [TEMP_W-1:0] rsp_temperature;
   logic signed [ANG_W-1:0] rsp_pitch, rsp_roll;
   logic rsp_calibrating, rsp_cal_done;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = '0;
   logic [8:0] csr_wdata = '0;

   imu_sample_scale_calibrate_tilt dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // predictor state
   logic [1:0] gyro_rng, accel_rng;
   logic [8:0] cal_lim;
   longint acc_ofs[3], gyr_ofs[3], acc_sum[3], gyr_sum[3];
   int cal_cnt;

   sample_out_type expected_q[$];
   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;

   function automatic longint clamp(longint v, int bits);
      longint hi, lo;
      hi = (longint'(1) << (bits - 1)) - 1;
      lo = -hi - 1;
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint round_div(longint n, longint d);
      longint m, q;
      m = n < 0 ? -n : n;
      q = (m + d / 2) / d;
      return n < 0 ? -q : q;
   endfunction

   function automatic longint shr_floor(longint v, int s);
      return v >= 0 ? (v >> s) : -((-v - 1) >> s) - 1;
   endfunction

   function automatic longint cordic_angle(longint x, longint y, output longint mag);
      longint ang, xs, ys;
      ang = 0;
      if (x == 0 && y == 0) begin
         mag = 0;
         return 0;
      end
      for (int i = 0; i < STEPS; i++) begin
         xs = shr_floor(x, i);
         ys = shr_floor(y, i);
         if (y >= 0) begin
            x += ys; y -= xs; ang += longint'(atan_entry(i[4:0]));
         end else begin
            x -= ys; y += xs; ang -= longint'(atan_entry(i[4:0]));
         end
      end
      mag = x;
      return ang;
   endfunction

   function automatic longint tilt_angle(longint num, longint a, longint b);
      longint g, m, ang, r;
      a = a < 0 ? -a : a;
      b = b < 0 ? -b : b;
      void'(cordic_angle(a * 4096, b * 4096, g));
      m = (g * 39797) >>> 16;
      ang = cordic_angle(m, num * 4096, g);
      r = round_div(ang, 1024);
      if (r > ANG_LIMIT) r = ANG_LIMIT;
      if (r < -ANG_LIMIT) r = -ANG_LIMIT;
      return r;
   endfunction

   function automatic longint gyro_scale(longint raw);
      return round_div(raw * longint'(gyro_recip(gyro_rng)), longint'(1) << 22);
   endfunction

   task automatic predict_sample(input logic act, input logic signed [RAW_W-1:0] raw[7]);
      sample_out_type e;
      longint sa[3], sg[3], ca[3], cg[3], av;
      int lim;
      e.done = 1'b0;
      if (act) begin
         if (cal_cnt == 0) begin
            for (int k = 0; k < 3; k++) begin
               acc_ofs[k] = 0; gyr_ofs[k] = 0; acc_sum[k] = 0; gyr_sum[k] = 0;
            end
         end
      end else if (cal_cnt != 0) begin
         for (int k = 0; k < 3; k++) begin
            acc_sum[k] = 0; gyr_sum[k] = 0;
         end
         cal_cnt = 0;
      end
      for (int k = 0; k < 3; k++) begin
         sa[k] = longint'(raw[k]) * (longint'(1) << accel_rng);
         sg[k] = gyro_scale(longint'(raw[4 + k]));
         ca[k] = clamp(sa[k] - acc_ofs[k], ACC_W);
         cg[k] = clamp(sg[k] - gyr_ofs[k], GYR_W);
      end
      e.temp = TEMP_W'(clamp(round_div(longint'(raw[3]) * 25600 + 317957120, 34000), TEMP_W));
      e.pitch = ANG_W'(tilt_angle(ca[1], ca[0], ca[2]));
      e.roll = ANG_W'(tilt_angle(-ca[0], ca[1], ca[2]));
      if (act) begin
         for (int k = 0; k < 3; k++) begin
            acc_sum[k] += sa[k]; gyr_sum[k] += sg[k];
         end
         cal_cnt++;
         lim = cal_lim == 0 ? 1 : int'(cal_lim);
         if (lim > MAX_CAL) lim = MAX_CAL;
         if (cal_cnt >= lim) begin
            for (int k = 0; k < 3; k++) begin
               av = round_div(acc_sum[k], cal_cnt);
               if (k == 2) av -= ONE_G;
               acc_ofs[k] = clamp(av, ACC_W);
               gyr_ofs[k] = clamp(round_div(gyr_sum[k], cal_cnt), GYR_W);
               acc_sum[k] = 0; gyr_sum[k] = 0;
            end
            cal_cnt = 0;
            e.done = 1'b1;
         end
      end
      e.ax = ACC_W'(ca[0]); e.ay = ACC_W'(ca[1]); e.az = ACC_W'(ca[2]);
      e.gx = GYR_W'(cg[0]); e.gy = GYR_W'(cg[1]); e.gz = GYR_W'(cg[2]);
      e.calibrating = cal_cnt != 0;
      expected_q.push_back(e);
   endtask

   // random idle bursts on the request side; drop valid for the gap
   task automatic idle_gap();
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic send_sample(input logic act, input logic signed [RAW_W-1:0] raw[7]);
      idle_gap();
      req_valid <= 1'b1;
      req_action <= act;
      req_raw_ax <= raw[0]; req_raw_ay <= raw[1]; req_raw_az <= raw[2];
      req_raw_temp <= raw[3];
      req_raw_gx <= raw[4]; req_raw_gy <= raw[5]; req_raw_gz <= raw[6];
      do @(posedge clock); while (req_stall);
      predict_sample(act, raw);
      @(negedge clock);
   endtask

   task automatic send_fields(input logic act, input int a0, a1, a2, t, g0, g1, g2);
      logic signed [RAW_W-1:0] raw[7];
      raw = '{RAW_W'(a0), RAW_W'(a1), RAW_W'(a2), RAW_W'(t), RAW_W'(g0), RAW_W'(g1),
              RAW_W'(g2)};
      send_sample(act, raw);
   endtask

   task automatic send_random(input logic act);
      logic signed [RAW_W-1:0] raw[7];
      for (int k = 0; k < 7; k++) begin
         case ($urandom_range(0, 3))
            0: raw[k] = RAW_W'($urandom);
            1: raw[k] = RAW_W'($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
            default: raw[k] = RAW_W'($signed($urandom_range(0, 4000)) - 2000);
         endcase
      end
      // keep z near one g in about half of the calibration beats so offsets stay realistic
      if (act && $urandom_range(0, 1))
         raw[2] = RAW_W'(16384 + $signed($urandom_range(0, 400)) - 200);
      send_sample(act, raw);
   endtask

   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_q.size() != 0 && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [8:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GYRO_RANGE:  gyro_rng = val[1:0];
         CSR_ACCEL_RANGE: accel_rng = val[1:0];
         CSR_CAL_SAMPLES: cal_lim = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(input logic [1:0] g, input logic [1:0] a, input logic [8:0] n);
      drain();
      write_reg(CSR_GYRO_RANGE, {7'd0, g});
      write_reg(CSR_ACCEL_RANGE, {7'd0, a});
      write_reg(CSR_CAL_SAMPLES, n);
      csr_valid <= 1'b0;
   endtask

   task automatic test_extremes();
      send_fields(0, 0, 0, 0, 0, 0, 0, 0);
      send_fields(0, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
      send_fields(0, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
      send_fields(0, 0, 16384, 0, -12000, 1, -1, 0);
      send_fields(0, -16384, 0, 0, 12000, -1, 1, 131);
      send_fields(0, 0, 0, 16384, 1, 65, -65, -131);
      send_fields(0, 0, 5, 0, 0, 0, 0, 0);
      configure(2'd3, 2'd3, 9'd100);
      send_fields(0, 32767, -32768, 32767, 0, 32767, -32768, 100);
      send_fields(0, -32768, 32767, -1, 0, -32768, 32767, -100);
   endtask

   task automatic test_calibration();
      configure(2'd1, 2'd2, 9'd3);
      send_fields(1, 100, -200, 16500, 0, 50, -60, 7);
      send_fields(1, 101, -201, 16400, 0, 51, -61, 8);
      send_fields(1, 99, -199, 16300, 0, 49, -59, 9);
      send_fields(0, 100, -200, 16400, 0, 50, -60, 8);
      // abort a run, then one-sample and zero-limit runs
      send_fields(1, 32767, 32767, -32768, 0, 32767, 32767, -32768);
      send_fields(0, 1, 2, 3, 4, 5, 6, 7);
      configure(2'd0, 2'd0, 9'd1);
      send_fields(1, -32768, -32768, 32767, 0, -32768, -32768, 32767);
      send_fields(0, 32767, 32767, -32768, 0, 32767, 32767, -32768);
      configure(2'd0, 2'd0, 9'd0);
      send_fields(1, 0, 0, 16384, 0, 0, 0, 0);
      // limit above the maximum acts as the maximum
      configure(2'd2, 2'd1, 9'd511);
      for (int i = 0; i < 257; i++) send_random(1'b1);
      send_random(1'b0);
      // lowering the limit mid-run ends it on the next calibration beat
      configure(2'd0, 2'd0, 9'd10);
      for (int i = 0; i < 4; i++) send_random(1'b1);
      configure(2'd0, 2'd0, 9'd2);
      send_random(1'b1);
      send_random(1'b0);
   endtask

   task automatic test_random();
      int run_len;
      for (int phase = 0; phase < 4; phase++) begin
         configure(2'($urandom), 2'($urandom),
                   phase == 3 ? 9'd256 : 9'($urandom_range(1, 12)));
         if (phase == 3) quiet = 1'b1;
         for (int i = 0; i < 12; i++) begin
            if ($urandom_range(0, 4) == 0) begin
               run_len = $urandom_range(1, 14);
               for (int j = 0; j < run_len; j++) send_random(1'b1);
            end else begin
               send_random(1'b0);
            end
         end
      end
   endtask

   // result checker and receiver-side stalls
   initial begin
      sample_out_type e;
      bit bad;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected result beat at cycle %0d", cycles);
            end else begin
               e = expected_q.pop_front();
               bad = e.ax !== rsp_accel_x || e.ay !== rsp_accel_y || e.az !== rsp_accel_z
                  || e.gx !== rsp_gyro_x || e.gy !== rsp_gyro_y || e.gz !== rsp_gyro_z
                  || e.temp !== rsp_temperature || e.pitch !== rsp_pitch
                  || e.roll !== rsp_roll || e.calibrating !== rsp_calibrating
                  || e.done !== rsp_cal_done;
               if (bad) begin
                  errors++;
                  if (errors <= 10)
                     $display("mismatch: exp a=%0d %0d %0d g=%0d %0d %0d t=%0d p=%0d r=%0d",
                        e.ax, e.ay, e.az, e.gx, e.gy, e.gz, e.temp, e.pitch, e.roll,
                        " c=%0b d=%0b", e.calibrating, e.done,
                        " got a=%0d %0d %0d g=%0d %0d %0d t=%0d p=%0d r=%0d",
                        rsp_accel_x, rsp_accel_y, rsp_accel_z,
                        rsp_gyro_x, rsp_gyro_y, rsp_gyro_z, rsp_temperature, rsp_pitch,
                        rsp_roll, " c=%0b d=%0b", rsp_calibrating, rsp_cal_done);
               end
            end
         end
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!quiet && $urandom_range(0, 15) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      gyro_rng = 0; accel_rng = 0; cal_lim = 9'd100;
      cal_cnt = 0;
      for (int k = 0; k < 3; k++) begin
         acc_ofs[k] = 0; gyr_ofs[k] = 0; acc_sum[k] = 0; gyr_sum[k] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_extremes();
      test_calibration();
      test_random();
      drain();
      if (errors == 0 && expected_q.size() == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
